/* rtl/core/lucas_binomial_divisibility_top_assert.svh */
// Assertion macros shared by the lucas_binomial_divisibility checker.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef LUCAS_BINOMIAL_DIVISIBILITY_TOP_ASSERT_SVH
`define LUCAS_BINOMIAL_DIVISIBILITY_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LBD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbd check failed");

// Next-cycle implication, disabled during reset.
`define LBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbd check failed");

`endif

/* rtl/core/lbd_pkg.sv */
// Package for the Lucas digit-domination block: word width, payload structs,
// sequencer states and divider-lane control. Depends on nothing.
package lbd_pkg;

  localparam int WORD_BITS = 64;
  localparam int CTR_BITS  = $clog2(WORD_BITS);

  typedef struct packed {
    logic [63:0] radix;
    logic [63:0] upper_value;
    logic [63:0] lower_value;
  } lbd_req_t;

  typedef struct packed {
    logic digit_exceeds;
    logic digits_dominated;
  } lbd_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } lbd_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic step;
  } lbd_lane_ctl_t;

endpackage

/* rtl/core/lucas_binomial_divisibility_top.sv */
// Channel | dir | payload   | transfer when
// req     | in  | lbd_req_t | req_valid && req_ready
// rsp     | out | lbd_rsp_t | rsp_valid && rsp_ready
//
// One request at a time. For each base-p digit the two bit-serial divider
// lanes (upper and lower) run one quotient bit per cycle, then ST_CHECK
// compares remainders and tests for zero. rst is synchronous and clears the
// sequencer and rsp_valid. A result waiting in the output register still lets
// one more request in; that request holds in ST_DONE until the waiting result
// transfers.
module lucas_binomial_divisibility_top import lbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  lbd_req_t req_data,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output lbd_rsp_t rsp_data
);

  lbd_state_t           state, state_next;
  logic [CTR_BITS-1:0]  ctr, ctr_next;
  logic [WORD_BITS-1:0] p;
  logic                 hit, hit_next;
  logic                 rsp_load;
  lbd_lane_ctl_t        lane_ctl;
  logic [WORD_BITS-1:0] m_quo, m_rem, t_quo, t_rem;
  logic                 req_xfer;
  logic                 p_small, vals_zero, rem_exceeds, last_bit;

  assign req_xfer    = req_valid && req_ready;
  assign p_small     = (p[WORD_BITS-1:1] == '0);
  assign vals_zero   = (m_quo == '0) && (t_quo == '0);
  assign rem_exceeds = (t_rem > m_rem);
  assign last_bit    = (ctr == CTR_BITS'(WORD_BITS - 1));

  lbd_div_lane u_lane_m (
    .clk      (clk),
    .ctl      (lane_ctl),
    .load_val (req_data.upper_value[WORD_BITS-1:0]),
    .divisor  (p),
    .quo      (m_quo),
    .rem      (m_rem)
  );

  lbd_div_lane u_lane_t (
    .clk      (clk),
    .ctl      (lane_ctl),
    .load_val (req_data.lower_value[WORD_BITS-1:0]),
    .divisor  (p),
    .quo      (t_quo),
    .rem      (t_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_xfer) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (rem_exceeds || p_small || vals_zero) state_next = ST_DONE;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (last_bit) state_next = ST_CHECK;
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    req_ready      = 1'b0;
    lane_ctl       = '0;
    ctr_next       = ctr;
    hit_next       = hit;
    rsp_load       = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready     = 1'b1;
        lane_ctl.load = req_xfer;
        hit_next      = 1'b0;
      end
      ST_CHECK: begin
        // remainders are zero on the first pass, so only a real digit can hit
        if (rem_exceeds) begin
          hit_next = 1'b1;
        end else if (p_small) begin
          hit_next = (t_quo > m_quo);
        end else if (!vals_zero) begin
          lane_ctl.clear = 1'b1;
          ctr_next       = '0;
        end
      end
      ST_DIV: begin
        lane_ctl.step = 1'b1;
        ctr_next      = ctr + CTR_BITS'(1);
      end
      ST_DONE: begin
        rsp_load = !rsp_valid || rsp_ready;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ctr <= ctr_next;
    hit <= hit_next;
    if (req_xfer) p <= req_data.radix[WORD_BITS-1:0];
    if (rsp_load) begin
      rsp_data.digit_exceeds    <= hit;
      rsp_data.digits_dominated <= !hit;
    end
  end

endmodule

/* rtl/core/lbd_div_lane.sv */
// Bit-serial restoring divider lane: one quotient bit per cycle while ctl.step is set.
// Depends on lbd_pkg for WORD_BITS and the lane control struct.
module lbd_div_lane import lbd_pkg::*; (
  input  logic                 clk,
  input  lbd_lane_ctl_t        ctl,
  input  logic [WORD_BITS-1:0] load_val,
  input  logic [WORD_BITS-1:0] divisor,
  output logic [WORD_BITS-1:0] quo,
  output logic [WORD_BITS-1:0] rem
);

  logic [WORD_BITS:0] partial;
  logic [WORD_BITS:0] diff;
  logic               fits;

  always_comb begin
    partial = {rem, quo[WORD_BITS-1]};
    diff    = partial - {1'b0, divisor};
    fits    = (partial >= {1'b0, divisor});
  end

  // quo holds the dividend and collects quotient bits from the bottom
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      quo <= load_val;
      rem <= '0;
    end else if (ctl.clear) begin
      rem <= '0;
    end else if (ctl.step) begin
      rem <= fits ? diff[WORD_BITS-1:0] : partial[WORD_BITS-1:0];
      quo <= {quo[WORD_BITS-2:0], fits};
    end
  end

endmodule

/* rtl/core/lbd_checker.sv */
// Port-level checker for lucas_binomial_divisibility_top, bound to the top level.
// Depends on lbd_pkg and lucas_binomial_divisibility_top_assert.svh.
`include "lucas_binomial_divisibility_top_assert.svh"

module lbd_checker import lbd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input lbd_req_t req_data,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input lbd_rsp_t rsp_data
);

  logic req_xfer;
  logic rsp_wait;
  logic flags_ok;

  assign req_xfer = req_valid && req_ready;
  assign rsp_wait = rsp_valid && !rsp_ready;
  assign flags_ok = (rsp_data.digit_exceeds != rsp_data.digits_dominated);

  // the two flags are opposite whenever rsp_valid is high
  `LBD_ASSERT_IMPL(a_flags_opposite, clk, rst, rsp_valid, flags_ok)
  // one request in the sequencer at a time: no transfer right after another
  `LBD_ASSERT_NEXT(a_one_in_flight, clk, rst, req_xfer, !req_ready)
  // a stalled result holds
  `LBD_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_wait, rsp_valid && $stable(rsp_data))

endmodule

bind lucas_binomial_divisibility_top lbd_checker u_lbd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req_data  (req_data),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

/* tb/lucas_binomial_divisibility_checker.sv */
// Scoreboard for the Lucas digit-domination block: watches the req and rsp
// channels, predicts each verdict and compares it with what comes out.
// Depends on lbd_pkg for the payload structs and WORD_BITS.
module lucas_binomial_divisibility_checker import lbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_ready,
  input  lbd_req_t req_data,
  input  logic     rsp_valid,
  input  logic     rsp_ready,
  input  lbd_rsp_t rsp_data,
  output int       mismatches,
  output int       in_flight
);

  typedef struct {
    lbd_req_t query;
    lbd_rsp_t verdict;
  } verdict_entry_t;

  verdict_entry_t verdicts_q[$];

  // Walk both values digit by digit in base p, least significant first.
  function automatic lbd_rsp_t predict_verdict(lbd_req_t q);
    logic [63:0] mask;
    logic [63:0] p;
    logic [63:0] m;
    logic [63:0] t;
    logic        hit;
    lbd_rsp_t    v;
    mask = (WORD_BITS >= 64) ? {64{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);
    p = q.radix & mask;
    m = q.upper_value & mask;
    t = q.lower_value & mask;
    hit = 1'b0;
    if (p < 64'd2) begin
      // no digit expansion: the whole value is one digit
      hit = (t > m);
    end else begin
      while ((m != 64'd0 || t != 64'd0) && !hit) begin
        if ((t % p) > (m % p)) hit = 1'b1;
        m = m / p;
        t = t / p;
      end
    end
    v.digit_exceeds    = hit;
    v.digits_dominated = !hit;
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_entry_t head;
    verdict_entry_t fresh;
    if (rst) begin
      verdicts_q.delete();
      mismatches = 0;
      in_flight  = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (verdicts_q.size() == 0) begin
          if (mismatches < 10)
            $display("rsp transfer with no request waiting: exceeds=%0b dominated=%0b",
                     rsp_data.digit_exceeds, rsp_data.digits_dominated);
          mismatches++;
        end else begin
          head = verdicts_q.pop_front();
          if (rsp_data.digit_exceeds !== head.verdict.digit_exceeds ||
              rsp_data.digits_dominated !== head.verdict.digits_dominated) begin
            if (mismatches < 10)
              $display("verdict mismatch p=%h m=%h t=%h: exp %0b/%0b got %0b/%0b",
                       head.query.radix, head.query.upper_value, head.query.lower_value,
                       head.verdict.digit_exceeds, head.verdict.digits_dominated,
                       rsp_data.digit_exceeds, rsp_data.digits_dominated);
            mismatches++;
          end
        end
      end
      if (req_valid && req_ready) begin
        fresh.query   = req_data;
        fresh.verdict = predict_verdict(req_data);
        verdicts_q.insert(verdicts_q.size(), fresh);
      end
      in_flight = verdicts_q.size();
    end
  end

endmodule

/* tb/lucas_binomial_divisibility_top_test.sv */
// Stimulus and verdict for lucas_binomial_divisibility_top: directed corners,
// a back-pressure burst, then random requests, most of them digit-shaped.
// Depends on lbd_pkg, the block and lucas_binomial_divisibility_checker.
module lucas_binomial_divisibility_top_test;
  import lbd_pkg::*;

  localparam int RANDOM_ITEMS = 112;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 4200;
  localparam int LIMIT_CYCLES = 3000000;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  lbd_req_t req_data;
  logic     rsp_valid;
  logic     rsp_ready;
  lbd_rsp_t rsp_data;

  int          mismatches;
  int          in_flight;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  bit          hold_armed = 1'b0;

  lucas_binomial_divisibility_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  lucas_binomial_divisibility_checker watch (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_data   (req_data),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp_data   (rsp_data),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_bits(int w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (w < 64) v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  function automatic lbd_req_t make_req(logic [63:0] p, logic [63:0] m, logic [63:0] t);
    lbd_req_t q;
    q.radix       = p;
    q.upper_value = m;
    q.lower_value = t;
    return q;
  endfunction

  // Build t digit by digit under m; with bump, push at most one digit just past m's.
  function automatic logic [63:0] shape_lower(logic [63:0] p, logic [63:0] m, bit bump);
    logic [63:0] rest;
    logic [63:0] place;
    logic [63:0] t;
    logic [63:0] dig;
    logic [63:0] td;
    bit          bumped;
    rest   = m;
    place  = 64'd1;
    t      = 64'd0;
    bumped = 1'b0;
    while (rest != 64'd0) begin
      dig = rest % p;
      td  = rand_bits(64) % (dig + 64'd1);
      if (bump && !bumped && dig < p - 64'd1 &&
          ($urandom_range(0, 2) == 0 || rest / p == 64'd0)) begin
        td     = dig + 64'd1;
        bumped = 1'b1;
      end
      t     = t + td * place;
      rest  = rest / p;
      place = place * p;
    end
    return t;
  endfunction

  function automatic lbd_req_t make_item();
    lbd_req_t    q;
    int          kind;
    int          shape;
    int          w;
    logic [63:0] p;
    kind = $urandom_range(0, 99);
    w    = $urandom_range(1, 64);
    if (kind < 4) begin
      p = 64'($urandom_range(0, 1));
    end else if (kind < 40) begin
      case ($urandom_range(0, 7))
        0: p = 64'd2;
        1: p = 64'd3;
        2: p = 64'd5;
        3: p = 64'd7;
        4: p = 64'd11;
        5: p = 64'd13;
        6: p = 64'd31;
        default: p = 64'd251;
      endcase
      // keep most small-radix values short so digit counts stay moderate
      if ($urandom_range(0, 9) != 0) w = $urandom_range(1, 20);
    end else if (kind < 70) begin
      p = rand_bits($urandom_range(3, 40)) | 64'd2;
    end else begin
      p = rand_bits($urandom_range(33, 64));
    end
    q.radix       = p;
    q.upper_value = rand_bits(w);
    shape = $urandom_range(0, 9);
    if (p < 64'd2 || shape < 3)
      q.lower_value = rand_bits($urandom_range(1, w));
    else
      q.lower_value = shape_lower(p, q.upper_value, shape < 5);
    return q;
  endfunction

  // Entered and left at a falling edge; valid stays up across back-to-back items.
  task automatic send_item(lbd_req_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= q;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    req_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    int stall;
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_armed) begin
        // hold off the receiver long enough for the request side to back up
        hold_armed = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          rsp_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corners: zero values, radix below two, widest values and radices
    send_item(make_req(64'd2, 64'd0, 64'd0));
    send_item(make_req(64'd0, 64'd5, 64'd9));
    send_item(make_req(64'd0, 64'd9, 64'd5));
    send_item(make_req(64'd0, 64'd0, 64'd0));
    send_item(make_req(64'd1, {64{1'b1}}, {64{1'b1}}));
    send_item(make_req(64'd1, 64'd0, 64'd1));
    send_item(make_req(64'd2, {64{1'b1}}, {64{1'b1}}));
    send_item(make_req(64'd2, {64{1'b1}}, 64'd0));
    send_item(make_req(64'd2, 64'd0, {64{1'b1}}));
    send_item(make_req(64'd2, 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000));
    send_item(make_req(64'd2, 64'h5555_5555_5555_5555, 64'h1111_1111_1111_1111));
    send_item(make_req(64'd2, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555));
    send_item(make_req(64'd3, 64'd10, 64'd3));
    send_item(make_req(64'd5, 64'd26, 64'd1));
    send_item(make_req(64'd4, 64'd6, 64'd3));
    send_item(make_req(64'd6, 64'd35, 64'd35));
    send_item(make_req(64'd7, 64'd100, 64'd200));
    send_item(make_req({64{1'b1}}, {64{1'b1}}, {64{1'b1}} - 64'd1));
    send_item(make_req({64{1'b1}}, {64{1'b1}} - 64'd1, 64'd5));
    send_item(make_req(64'h8000_0000_0000_0000, {64{1'b1}}, 64'h7fff_ffff_ffff_ffff));
    send_item(make_req(64'hffff_ffff_ffff_ffc5, {64{1'b1}}, {64{1'b1}}));
    wait_all_results();

    // back-pressure burst: short requests offered back to back into a held receiver
    hold_armed = 1'b1;
    calm = 1'b1;
    repeat (8)
      send_item(make_req(rand_bits(64) | 64'h8000_0000_0000_0000, rand_bits(64),
                         rand_bits(64)));
    calm = 1'b0;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 16 == 0) calm = ($urandom_range(0, 3) == 0);
      send_item(make_item());
      if (i == RANDOM_ITEMS / 2) wait_all_results();
    end

    req_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && in_flight == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* lucas_binomial_divisibility_top.f */
+incdir+rtl/core
rtl/core/lbd_pkg.sv
rtl/core/lbd_div_lane.sv
rtl/core/lucas_binomial_divisibility_top.sv
rtl/core/lbd_checker.sv
tb/lucas_binomial_divisibility_checker.sv
tb/lucas_binomial_divisibility_top_test.sv
